// ===== design/bssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssa_pkg
// Shared types, widths and helpers of the selective Brier score accumulator.
// ----------------------------------------------------------------------------
package bssa_pkg;

  localparam int FRAC_BITS   = 15;
  localparam int SIG_W       = FRAC_BITS + 2;
  localparam int WEIGHT_W    = FRAC_BITS + 1;
  localparam int SIGMA_W     = FRAC_BITS + 1;
  localparam int PROD_W      = WEIGHT_W + FRAC_BITS;
  localparam int SUM_W       = PROD_W + 2;
  localparam int SQ_W        = 2 * FRAC_BITS + 1;
  localparam int SSE_W       = 47;
  localparam int CNT_W       = 17;
  localparam int MAX_ROWS    = 65536;
  localparam int RATIO_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIVIDEND_W  = SSE_W - FRAC_BITS;
  localparam int DIVISOR_W   = CNT_W;
  localparam int DIV_STEP_W  = $clog2(DIVIDEND_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIGMA_W-1:0]  ONE     = SIGMA_W'(1) << FRAC_BITS;
  localparam logic [SSE_W-1:0]    SSE_MAX = {SSE_W{1'b1}};
  localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_ROWS);

  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_LOGPROB     = 16'd16384;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ENTROPY     = 16'd6554;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_PERPLEXITY  = 16'd3277;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CONSISTENCY = 16'd6554;
  localparam logic [WEIGHT_W-1:0] RST_ACCEPT_THRESHOLD   = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_LOGPROB     = 3'd0,
    REG_WEIGHT_ENTROPY     = 3'd1,
    REG_WEIGHT_PERPLEXITY  = 3'd2,
    REG_WEIGHT_CONSISTENCY = 3'd3,
    REG_ACCEPT_THRESHOLD   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_FETCH,
    BACK_BRIER,
    BACK_COV,
    BACK_ACC,
    BACK_HOLD
  } back_state_t;

  typedef struct packed {
    logic [SSE_W-1:0] sse;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] accepted;
    logic [CNT_W-1:0] correct_accepted;
  } batch_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  function automatic logic [SIGMA_W-1:0] clamp_signal(input logic [SIG_W-1:0] s);
    logic [SIGMA_W-1:0] r;
    if (s[SIG_W-1]) begin
      r = '0;
    end else if (s[SIGMA_W-1:0] > ONE) begin
      r = ONE;
    end else begin
      r = s[SIGMA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c < CNT_MAX) ? c + CNT_W'(1) : CNT_MAX;
    return r;
  endfunction

endpackage

// ===== design/bssa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssa_queue
// Small batch-total queue between the row front end and the ratio back end.
// ----------------------------------------------------------------------------
module bssa_queue #(
  parameter int DEPTH = bssa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bssa_pkg::batch_t push_data,
  input  logic             pop,
  output bssa_pkg::batch_t pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bssa_pkg::batch_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             full;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("batch queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("batch queue underflow");

endmodule

// ===== design/bssa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssa_front
// Configuration registers and row pipeline: clamp, weighted sum, squared
// error and the saturating batch accumulators.
// ----------------------------------------------------------------------------
module bssa_front #(
  parameter int QUEUE_DEPTH = bssa_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bssa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bssa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_logprob,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_entropy,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_perplexity,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_consistency,
  input  logic                                  is_correct,
  input  logic                                  last_item,
  output logic                                  push,
  output bssa_pkg::batch_t                      push_data,
  input  logic                                  pop
);

  localparam int CR_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WIDE_W = 2 * bssa_pkg::WEIGHT_W;

  logic [bssa_pkg::WEIGHT_W-1:0] weight [4];
  logic [bssa_pkg::WEIGHT_W-1:0] accept_threshold;

  logic [CR_W-1:0] credits;
  logic [CR_W-1:0] credits_next;
  logic            take;

  logic [bssa_pkg::SIGMA_W-1:0] sig_clamped [4];
  logic [WIDE_W-1:0]            prod_full   [4];

  logic                         s1_valid;
  logic                         s1_correct;
  logic                         s1_last;
  logic [bssa_pkg::PROD_W-1:0]  s1_prod [4];

  logic [bssa_pkg::SUM_W-1:0]   sum;
  logic [bssa_pkg::SUM_W-bssa_pkg::FRAC_BITS-1:0] sigma_raw;
  logic [bssa_pkg::SIGMA_W-1:0] sigma;
  logic [bssa_pkg::SIGMA_W-1:0] err;

  logic                         s2_valid;
  logic                         s2_correct;
  logic                         s2_last;
  logic                         s2_accept;
  logic [bssa_pkg::SIGMA_W-1:0] s2_err;

  logic [WIDE_W-1:0]            sq_full;
  logic                         s3_valid;
  logic                         s3_correct;
  logic                         s3_last;
  logic                         s3_accept;
  logic [bssa_pkg::SQ_W-1:0]    s3_sq;

  logic [bssa_pkg::SSE_W-1:0]   sse;
  logic [bssa_pkg::CNT_W-1:0]   rows;
  logic [bssa_pkg::CNT_W-1:0]   accepted;
  logic [bssa_pkg::CNT_W-1:0]   correct_accepted;
  logic [bssa_pkg::SSE_W:0]     sse_sum;
  bssa_pkg::batch_t             batch_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight[0]        <= bssa_pkg::RST_WEIGHT_LOGPROB;
      weight[1]        <= bssa_pkg::RST_WEIGHT_ENTROPY;
      weight[2]        <= bssa_pkg::RST_WEIGHT_PERPLEXITY;
      weight[3]        <= bssa_pkg::RST_WEIGHT_CONSISTENCY;
      accept_threshold <= bssa_pkg::RST_ACCEPT_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bssa_pkg::REG_WEIGHT_LOGPROB:     weight[0] <= cfg_data;
        bssa_pkg::REG_WEIGHT_ENTROPY:     weight[1] <= cfg_data;
        bssa_pkg::REG_WEIGHT_PERPLEXITY:  weight[2] <= cfg_data;
        bssa_pkg::REG_WEIGHT_CONSISTENCY: weight[3] <= cfg_data;
        bssa_pkg::REG_ACCEPT_THRESHOLD:   accept_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // one queue slot is reserved per last row in flight or queued
  assign in_ready = (credits < CR_W'(QUEUE_DEPTH));
  assign take     = in_valid && in_ready;

  always_comb begin
    credits_next = credits;
    if (take && last_item) begin
      credits_next = credits_next + CR_W'(1);
    end
    if (pop) begin
      credits_next = credits_next - CR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  // stage 1: clamp and weight
  assign sig_clamped[0] = bssa_pkg::clamp_signal(sig_logprob);
  assign sig_clamped[1] = bssa_pkg::clamp_signal(sig_entropy);
  assign sig_clamped[2] = bssa_pkg::clamp_signal(sig_perplexity);
  assign sig_clamped[3] = bssa_pkg::clamp_signal(sig_consistency);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_full[i] = WIDE_W'(weight[i]) * WIDE_W'(sig_clamped[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1_prod[i] <= prod_full[i][bssa_pkg::PROD_W-1:0];
    end
    s1_correct <= is_correct;
    s1_last    <= last_item;
  end

  // stage 2: sum, clamp and error
  assign sum = bssa_pkg::SUM_W'(s1_prod[0]) + bssa_pkg::SUM_W'(s1_prod[1])
             + bssa_pkg::SUM_W'(s1_prod[2]) + bssa_pkg::SUM_W'(s1_prod[3]);
  assign sigma_raw = sum[bssa_pkg::SUM_W-1:bssa_pkg::FRAC_BITS];
  assign sigma = (sigma_raw > ($bits(sigma_raw))'(bssa_pkg::ONE))
               ? bssa_pkg::ONE : sigma_raw[bssa_pkg::SIGMA_W-1:0];
  assign err = s1_correct ? sigma : bssa_pkg::ONE - sigma;

  always_ff @(posedge clk) begin
    s2_err     <= err;
    s2_accept  <= (sigma <= accept_threshold);
    s2_correct <= s1_correct;
    s2_last    <= s1_last;
  end

  // stage 3: square
  assign sq_full = WIDE_W'(s2_err) * WIDE_W'(s2_err);

  always_ff @(posedge clk) begin
    s3_sq      <= sq_full[bssa_pkg::SQ_W-1:0];
    s3_accept  <= s2_accept;
    s3_correct <= s2_correct;
    s3_last    <= s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 4: saturating accumulate
  assign sse_sum = (bssa_pkg::SSE_W + 1)'(sse) + (bssa_pkg::SSE_W + 1)'(s3_sq);

  always_comb begin
    batch_next.sse  = sse_sum[bssa_pkg::SSE_W] ? bssa_pkg::SSE_MAX
                                               : sse_sum[bssa_pkg::SSE_W-1:0];
    batch_next.rows = bssa_pkg::sat_inc(rows);
    batch_next.accepted         = accepted;
    batch_next.correct_accepted = correct_accepted;
    if (s3_accept) begin
      batch_next.accepted = bssa_pkg::sat_inc(accepted);
      if (s3_correct) begin
        batch_next.correct_accepted = bssa_pkg::sat_inc(correct_accepted);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sse              <= '0;
      rows             <= '0;
      accepted         <= '0;
      correct_accepted <= '0;
    end else if (s3_valid) begin
      if (s3_last) begin
        sse              <= '0;
        rows             <= '0;
        accepted         <= '0;
        correct_accepted <= '0;
      end else begin
        sse              <= batch_next.sse;
        rows             <= batch_next.rows;
        accepted         <= batch_next.accepted;
        correct_accepted <= batch_next.correct_accepted;
      end
    end
  end

  assign push      = s3_valid && s3_last;
  assign push_data = batch_next;

  a_credit_taken: assert property (@(posedge clk) disable iff (rst)
      (take && last_item && !pop) |=> (credits != '0))
    else $error("last row accepted without a reserved queue slot");

endmodule

// ===== design/bssa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bssa_div (
  input  logic                              clk,
  input  logic                              rst,
  input  bssa_pkg::div_req_t                req,
  output logic                              done,
  output logic [bssa_pkg::DIVIDEND_W-1:0]   quotient
);

  logic                                busy;
  logic [bssa_pkg::DIV_STEP_W-1:0]     step;
  logic [bssa_pkg::DIVISOR_W-1:0]      divisor;
  logic [bssa_pkg::DIVISOR_W-1:0]      rem;
  logic [bssa_pkg::DIVISOR_W:0]        rem_shift;
  logic [bssa_pkg::DIVISOR_W:0]        rem_diff;
  logic                                fits;

  assign rem_shift = {rem, quotient[bssa_pkg::DIVIDEND_W-1]};
  assign rem_diff  = rem_shift - (bssa_pkg::DIVISOR_W + 1)'(divisor);
  assign fits      = (rem_shift >= (bssa_pkg::DIVISOR_W + 1)'(divisor));

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[bssa_pkg::DIVIDEND_W-2:0], fits};
      rem      <= fits ? rem_diff[bssa_pkg::DIVISOR_W-1:0]
                       : rem_shift[bssa_pkg::DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + bssa_pkg::DIV_STEP_W'(1);
        if (step == bssa_pkg::DIV_STEP_W'(bssa_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/bssa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssa_back
// Per-batch ratios on a shared divider and the result output register.
// ----------------------------------------------------------------------------
module bssa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  output logic                              pop,
  input  bssa_pkg::batch_t                  head,
  output bssa_pkg::div_req_t                div_req,
  input  logic                              div_done,
  input  logic [bssa_pkg::DIVIDEND_W-1:0]   div_quotient,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bssa_pkg::RATIO_W-1:0]      brier,
  output logic [bssa_pkg::RATIO_W-1:0]      coverage,
  output logic [bssa_pkg::RATIO_W-1:0]      accept_accuracy,
  output logic [bssa_pkg::CNT_W-1:0]        item_total,
  output logic [bssa_pkg::CNT_W-1:0]        accept_total,
  output logic [bssa_pkg::CNT_W-1:0]        correct_accept_total,
  output logic [bssa_pkg::SSE_W-1:0]        squared_error_sum
);

  bssa_pkg::back_state_t state;
  bssa_pkg::back_state_t state_next;

  logic [bssa_pkg::RATIO_W-1:0] q_brier;
  logic [bssa_pkg::RATIO_W-1:0] q_cov;
  logic [bssa_pkg::RATIO_W-1:0] q_acc;
  logic                         load;
  logic                         none_accepted;

  assign none_accepted = (head.accepted == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      bssa_pkg::BACK_IDLE:  if (!empty) state_next = bssa_pkg::BACK_FETCH;
      bssa_pkg::BACK_FETCH: state_next = bssa_pkg::BACK_BRIER;
      bssa_pkg::BACK_BRIER: if (div_done) state_next = bssa_pkg::BACK_COV;
      bssa_pkg::BACK_COV: begin
        if (div_done) begin
          state_next = none_accepted ? bssa_pkg::BACK_HOLD : bssa_pkg::BACK_ACC;
        end
      end
      bssa_pkg::BACK_ACC:   if (div_done) state_next = bssa_pkg::BACK_HOLD;
      bssa_pkg::BACK_HOLD:  if (load) state_next = bssa_pkg::BACK_IDLE;
      default:              state_next = bssa_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    pop              = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      bssa_pkg::BACK_IDLE: pop = !empty;
      bssa_pkg::BACK_FETCH: begin
        div_req.start    = 1'b1;
        div_req.dividend = head.sse[bssa_pkg::SSE_W-1:bssa_pkg::FRAC_BITS];
        div_req.divisor  = head.rows;
      end
      bssa_pkg::BACK_BRIER: begin
        div_req.start    = div_done;
        div_req.dividend = {head.accepted, bssa_pkg::FRAC_BITS'(0)};
        div_req.divisor  = head.rows;
      end
      bssa_pkg::BACK_COV: begin
        div_req.start    = div_done && !none_accepted;
        div_req.dividend = {head.correct_accepted, bssa_pkg::FRAC_BITS'(0)};
        div_req.divisor  = head.accepted;
      end
      bssa_pkg::BACK_ACC: ;
      bssa_pkg::BACK_HOLD: load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bssa_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (state)
        bssa_pkg::BACK_BRIER: q_brier <= div_quotient[bssa_pkg::RATIO_W-1:0];
        bssa_pkg::BACK_COV: begin
          q_cov <= div_quotient[bssa_pkg::RATIO_W-1:0];
          q_acc <= '0;
        end
        bssa_pkg::BACK_ACC:   q_acc <= div_quotient[bssa_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      brier                <= q_brier;
      coverage             <= q_cov;
      accept_accuracy      <= q_acc;
      item_total           <= head.rows;
      accept_total         <= head.accepted;
      correct_accept_total <= head.correct_accepted;
      squared_error_sum    <= head.sse;
    end
  end

  a_acc_needs_accepts: assert property (@(posedge clk) disable iff (rst)
      (state == bssa_pkg::BACK_ACC) |-> !none_accepted)
    else $error("accuracy division started with no accepted rows");

endmodule

// ===== design/brier_selective_score_accumulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brier_selective_score_accumulator_top
// Selective Brier score accumulator over a stream of scored rows.
// ----------------------------------------------------------------------------
// usage
//   input channel: one row per request (four signed Q2.15 signals, is_correct,
//   last_item); rows are taken one per cycle while fewer than QUEUE_DEPTH
//   batch ends are in flight or queued
//   output channel: one result request per batch, after its last row
//   config port: cfg_we / cfg_index / cfg_data, written while no row is in flight
//   data path: a taken row passes the stage 1, 2 and 3 registers before it
//   reaches the accumulators; a batch leaves the queue for the back end, which
//   runs up to three divisions on the shared 32-step divider in FETCH, BRIER,
//   COV and ACC (two when no row was accepted) and then loads the result in HOLD
//   throughput: one row per cycle while in_ready is high; the back end works on
//   one batch at a time, the next waiting in the queue until it is idle again
//   reset: weights and threshold load their defaults, accumulators clear
//   receiver stall: the result is held in the output register, the back end
//   then waits, the queue fills and in_ready drops at QUEUE_DEPTH open batches
// ----------------------------------------------------------------------------
module brier_selective_score_accumulator_top #(
  parameter int QUEUE_DEPTH = bssa_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bssa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bssa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_logprob,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_entropy,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_perplexity,
  input  logic signed [bssa_pkg::SIG_W-1:0]     sig_consistency,
  input  logic                                  is_correct,
  input  logic                                  last_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bssa_pkg::RATIO_W-1:0]          brier,
  output logic [bssa_pkg::RATIO_W-1:0]          coverage,
  output logic [bssa_pkg::RATIO_W-1:0]          accept_accuracy,
  output logic [bssa_pkg::CNT_W-1:0]            item_total,
  output logic [bssa_pkg::CNT_W-1:0]            accept_total,
  output logic [bssa_pkg::CNT_W-1:0]            correct_accept_total,
  output logic [bssa_pkg::SSE_W-1:0]            squared_error_sum
);

  logic                              push;
  bssa_pkg::batch_t                  push_data;
  logic                              pop;
  bssa_pkg::batch_t                  head;
  logic                              empty;
  bssa_pkg::div_req_t                div_req;
  logic                              div_done;
  logic [bssa_pkg::DIVIDEND_W-1:0]   div_quotient;

  bssa_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sig_logprob     (sig_logprob),
    .sig_entropy     (sig_entropy),
    .sig_perplexity  (sig_perplexity),
    .sig_consistency (sig_consistency),
    .is_correct      (is_correct),
    .last_item       (last_item),
    .push            (push),
    .push_data       (push_data),
    .pop             (pop)
  );

  bssa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  bssa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  bssa_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .empty                (empty),
    .pop                  (pop),
    .head                 (head),
    .div_req              (div_req),
    .div_done             (div_done),
    .div_quotient         (div_quotient),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .brier                (brier),
    .coverage             (coverage),
    .accept_accuracy      (accept_accuracy),
    .item_total           (item_total),
    .accept_total         (accept_total),
    .correct_accept_total (correct_accept_total),
    .squared_error_sum    (squared_error_sum)
  );

endmodule

// ===== tb/sv/brier_selective_score_accumulator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brier_selective_score_accumulator_top_tb
// Self-checking bench for the selective Brier score accumulator. Rows go in
// over a valid/ready channel, in random bursts in four random phases, while
// the result side stalls on its own pattern outside two steady phases. A
// scoring model in the bench predicts every batch result, checked field by
// field. The run covers directed edge rows, register extremes, a register
// change inside a batch, and random batches under several register settings.
// ----------------------------------------------------------------------------
module brier_selective_score_accumulator_top_tb;

  localparam int REG_COUNT     = int'(bssa_pkg::REG_ACCEPT_THRESHOLD) + 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES    = 150;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ROWS   = 1550;
  localparam int NUM_PHASES    = 6;

  localparam longint unsigned ROW_CAP = longint'(bssa_pkg::MAX_ROWS);
  localparam longint unsigned ONE_L   = 64'(bssa_pkg::ONE);
  localparam longint unsigned SSE_CAP = 64'(bssa_pkg::SSE_MAX);

  localparam logic signed [bssa_pkg::SIG_W-1:0] SIG_ONE      = 17'sd32768;
  localparam logic signed [bssa_pkg::SIG_W-1:0] SIG_MOST_POS =
      {1'b0, {(bssa_pkg::SIG_W-1){1'b1}}};
  localparam logic signed [bssa_pkg::SIG_W-1:0] SIG_MOST_NEG =
      {1'b1, {(bssa_pkg::SIG_W-1){1'b0}}};
  localparam logic [bssa_pkg::CFG_DATA_W-1:0]   REG_FULL     = '1;

  typedef struct {
    logic [bssa_pkg::RATIO_W-1:0] brier;
    logic [bssa_pkg::RATIO_W-1:0] coverage;
    logic [bssa_pkg::RATIO_W-1:0] accuracy;
    logic [bssa_pkg::CNT_W-1:0]   rows;
    logic [bssa_pkg::CNT_W-1:0]   accepted;
    logic [bssa_pkg::CNT_W-1:0]   correct_accepted;
    logic [bssa_pkg::SSE_W-1:0]   sse;
  } batch_score_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_we;
  logic [bssa_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [bssa_pkg::CFG_DATA_W-1:0]    cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [bssa_pkg::SIG_W-1:0]  sig_logprob;
  logic signed [bssa_pkg::SIG_W-1:0]  sig_entropy;
  logic signed [bssa_pkg::SIG_W-1:0]  sig_perplexity;
  logic signed [bssa_pkg::SIG_W-1:0]  sig_consistency;
  logic                               is_correct;
  logic                               last_item;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [bssa_pkg::RATIO_W-1:0]       brier;
  logic [bssa_pkg::RATIO_W-1:0]       coverage;
  logic [bssa_pkg::RATIO_W-1:0]       accept_accuracy;
  logic [bssa_pkg::CNT_W-1:0]         item_total;
  logic [bssa_pkg::CNT_W-1:0]         accept_total;
  logic [bssa_pkg::CNT_W-1:0]         correct_accept_total;
  logic [bssa_pkg::SSE_W-1:0]         squared_error_sum;

  // scoring model state
  longint unsigned weight_reg [4];
  longint unsigned threshold_reg;
  longint unsigned sse_acc = 0;
  longint unsigned rows_seen = 0;
  longint unsigned rows_accepted = 0;
  longint unsigned rows_correct_accepted = 0;
  batch_score_t    pending_scores [$];

  int mismatches = 0;
  int rows_sent = 0;
  int batches_checked = 0;
  int register_writes = 0;
  int stall_cycles = 0;
  int burst_left = 1;
  int rx_left = 0;
  bit rx_open = 1'b0;
  bit tx_bursty = 1'b0;
  bit rx_steady = 1'b0;

  brier_selective_score_accumulator_top i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .sig_logprob          (sig_logprob),
    .sig_entropy          (sig_entropy),
    .sig_perplexity       (sig_perplexity),
    .sig_consistency      (sig_consistency),
    .is_correct           (is_correct),
    .last_item            (last_item),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .brier                (brier),
    .coverage             (coverage),
    .accept_accuracy      (accept_accuracy),
    .item_total           (item_total),
    .accept_total         (accept_total),
    .correct_accept_total (correct_accept_total),
    .squared_error_sum    (squared_error_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("batch %0d %s expected %0d got %0d",
                                batches_checked, name, want, got));
    end
  endtask

  function automatic longint unsigned clip_to_one(
      input logic signed [bssa_pkg::SIG_W-1:0] s);
    longint unsigned r;
    if (s < 0) begin
      r = 0;
    end else if (s > SIG_ONE) begin
      r = ONE_L;
    end else begin
      r = 64'(s);
    end
    return r;
  endfunction

  // scores one accepted row and queues the batch result on the last row
  task automatic score_row(input logic signed [bssa_pkg::SIG_W-1:0] lp, en, px, cs,
                           input logic correct, input logic last);
    longint unsigned sig [4];
    longint unsigned total;
    longint unsigned sigma;
    longint unsigned target;
    longint unsigned err;
    longint unsigned sq;
    batch_score_t    s;
    sig[0] = clip_to_one(lp);
    sig[1] = clip_to_one(en);
    sig[2] = clip_to_one(px);
    sig[3] = clip_to_one(cs);
    total = 0;
    for (int i = 0; i < 4; i++) begin
      total += weight_reg[i] * sig[i];
    end
    sigma = total >> bssa_pkg::FRAC_BITS;
    if (sigma > ONE_L) begin
      sigma = ONE_L;
    end
    target = correct ? 64'd0 : ONE_L;
    err = (sigma >= target) ? sigma - target : target - sigma;
    sq = err * err;
    if (sse_acc > SSE_CAP - sq) begin
      sse_acc = SSE_CAP;
    end else begin
      sse_acc += sq;
    end
    rows_seen = (rows_seen < ROW_CAP) ? rows_seen + 1 : ROW_CAP;
    if (sigma <= threshold_reg) begin
      rows_accepted = (rows_accepted < ROW_CAP) ? rows_accepted + 1 : ROW_CAP;
      if (correct) begin
        rows_correct_accepted = (rows_correct_accepted < ROW_CAP) ?
                                rows_correct_accepted + 1 : ROW_CAP;
      end
    end
    if (last) begin
      s.brier            = bssa_pkg::RATIO_W'((sse_acc / rows_seen) >> bssa_pkg::FRAC_BITS);
      s.coverage         = bssa_pkg::RATIO_W'((rows_accepted << bssa_pkg::FRAC_BITS) /
                                              rows_seen);
      s.accuracy         = (rows_accepted == 0) ? '0 :
                           bssa_pkg::RATIO_W'((rows_correct_accepted << bssa_pkg::FRAC_BITS) /
                                              rows_accepted);
      s.rows             = bssa_pkg::CNT_W'(rows_seen);
      s.accepted         = bssa_pkg::CNT_W'(rows_accepted);
      s.correct_accepted = bssa_pkg::CNT_W'(rows_correct_accepted);
      s.sse              = bssa_pkg::SSE_W'(sse_acc);
      pending_scores.push_back(s);
      sse_acc = 0;
      rows_seen = 0;
      rows_accepted = 0;
      rows_correct_accepted = 0;
    end
  endtask

  task automatic send_row(input logic signed [bssa_pkg::SIG_W-1:0] lp, en, px, cs,
                          input logic correct, input logic last);
    in_valid        <= 1'b1;
    sig_logprob     <= lp;
    sig_entropy     <= en;
    sig_perplexity  <= px;
    sig_consistency <= cs;
    is_correct      <= correct;
    last_item       <= last;
    do @(posedge clk); while (!in_ready);
    score_row(lp, en, px, cs, correct, last);
    rows_sent++;
  endtask

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (tx_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = int'($urandom_range(1, 12));
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 80)) :
                     int'($urandom_range(1, 16));
      end
    end
  endtask

  // stop sending, wait for every pending result, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [bssa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bssa_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bssa_pkg::REG_WEIGHT_LOGPROB:     weight_reg[0] = 64'(data);
      bssa_pkg::REG_WEIGHT_ENTROPY:     weight_reg[1] = 64'(data);
      bssa_pkg::REG_WEIGHT_PERPLEXITY:  weight_reg[2] = 64'(data);
      bssa_pkg::REG_WEIGHT_CONSISTENCY: weight_reg[3] = 64'(data);
      bssa_pkg::REG_ACCEPT_THRESHOLD:   threshold_reg = 64'(data);
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic load_registers(input logic [bssa_pkg::CFG_DATA_W-1:0] weight,
                                input logic [bssa_pkg::CFG_DATA_W-1:0] threshold);
    for (int i = 0; i < REG_COUNT; i++) begin
      write_register(bssa_pkg::CFG_IDX_W'(i),
                     (i == int'(bssa_pkg::REG_ACCEPT_THRESHOLD)) ? threshold : weight);
    end
  endtask

  function automatic logic signed [bssa_pkg::SIG_W-1:0] rand_signal();
    logic signed [bssa_pkg::SIG_W-1:0] r;
    case ($urandom_range(0, 7))
      0: r = bssa_pkg::SIG_W'($urandom_range(0, (1 << bssa_pkg::SIG_W) - 1));
      1: r = bssa_pkg::SIG_W'(-int'($urandom_range(1, 1 << (bssa_pkg::SIG_W - 1))));
      2: r = bssa_pkg::SIG_W'($urandom_range(int'(bssa_pkg::ONE) - 8,
                                             int'(bssa_pkg::ONE) + 32));
      default: r = bssa_pkg::SIG_W'($urandom_range(0, int'(bssa_pkg::ONE)));
    endcase
    return r;
  endfunction

  function automatic logic [bssa_pkg::CFG_DATA_W-1:0] rand_register_value();
    logic [bssa_pkg::CFG_DATA_W-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = bssa_pkg::ONE;
      2: r = bssa_pkg::CFG_DATA_W'($urandom_range(0, (1 << bssa_pkg::CFG_DATA_W) - 1));
      default: r = bssa_pkg::CFG_DATA_W'($urandom_range(0, int'(bssa_pkg::ONE)));
    endcase
    return r;
  endfunction

  task automatic test_reset_defaults();
    send_row('0, '0, '0, '0, 1'b1, 1'b1);
    // sigma equal to the threshold
    send_row(SIG_ONE, '0, '0, '0, 1'b1, 1'b0);
    // default weights sum just above one
    send_row(SIG_ONE, SIG_ONE, SIG_ONE, SIG_ONE, 1'b0, 1'b0);
    send_row(17'sd32767, 17'sd1, '0, '0, 1'b0, 1'b1);
    // batch with nothing accepted
    send_row(SIG_ONE, SIG_ONE, '0, '0, 1'b1, 1'b1);
  endtask

  task automatic test_signal_clamping();
    send_row(SIG_MOST_NEG, -17'sd1, SIG_MOST_POS, 17'sd32769, 1'b0, 1'b0);
    send_row(17'sd32769, SIG_MOST_POS, -17'sd1, SIG_MOST_NEG, 1'b1, 1'b0);
    send_row(17'sd1, 17'sd32767, 17'sd16384, -17'sd32768, 1'b0, 1'b0);
    send_row(SIG_MOST_POS, SIG_MOST_POS, SIG_MOST_POS, SIG_MOST_POS, 1'b1, 1'b1);
  endtask

  task automatic test_register_extremes();
    drain_results();
    load_registers('0, '0);
    send_row(SIG_ONE, SIG_ONE, SIG_ONE, SIG_ONE, 1'b0, 1'b0);
    send_row(SIG_ONE, SIG_ONE, SIG_ONE, SIG_ONE, 1'b1, 1'b1);
    drain_results();
    load_registers(bssa_pkg::ONE, bssa_pkg::ONE);
    send_row(SIG_ONE, '0, '0, '0, 1'b1, 1'b0);
    send_row(SIG_ONE, SIG_ONE, SIG_ONE, SIG_ONE, 1'b0, 1'b0);
    send_row('0, '0, '0, 17'sd1, 1'b1, 1'b1);
    drain_results();
    // weights and threshold above one
    load_registers(REG_FULL, REG_FULL);
    send_row(17'sd1, 17'sd1, 17'sd1, 17'sd1, 1'b1, 1'b0);
    send_row(SIG_ONE, '0, '0, '0, 1'b0, 1'b1);
    drain_results();
    // writes past the register list change nothing
    for (int i = REG_COUNT; i < (1 << bssa_pkg::CFG_IDX_W); i++) begin
      write_register(bssa_pkg::CFG_IDX_W'(i), '0);
    end
    send_row(SIG_ONE, SIG_ONE, SIG_ONE, SIG_ONE, 1'b1, 1'b1);
  endtask

  task automatic test_mid_batch_update();
    drain_results();
    write_register(bssa_pkg::REG_WEIGHT_LOGPROB, bssa_pkg::RST_WEIGHT_LOGPROB);
    write_register(bssa_pkg::REG_WEIGHT_ENTROPY, bssa_pkg::RST_WEIGHT_ENTROPY);
    write_register(bssa_pkg::REG_WEIGHT_PERPLEXITY, bssa_pkg::RST_WEIGHT_PERPLEXITY);
    write_register(bssa_pkg::REG_WEIGHT_CONSISTENCY, bssa_pkg::RST_WEIGHT_CONSISTENCY);
    write_register(bssa_pkg::REG_ACCEPT_THRESHOLD, bssa_pkg::RST_ACCEPT_THRESHOLD);
    send_row(17'sd16384, 17'sd16384, 17'sd16384, 17'sd16384, 1'b1, 1'b0);
    send_row(17'sd16384, 17'sd16384, 17'sd16384, 17'sd16384, 1'b0, 1'b0);
    drain_results();
    write_register(bssa_pkg::REG_ACCEPT_THRESHOLD, bssa_pkg::RST_ACCEPT_THRESHOLD - 16'd1);
    send_row(17'sd16384, 17'sd16384, 17'sd16384, 17'sd16384, 1'b1, 1'b0);
    send_row('0, '0, '0, '0, 1'b1, 1'b1);
  endtask

  task automatic test_random_batches();
    int phase_rows;
    int batch_len;
    bit paused;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      tx_bursty = (phase % 3) != 0;
      rx_steady = (phase == 0) || (phase == 4);
      for (int i = 0; i < REG_COUNT; i++) begin
        write_register(bssa_pkg::CFG_IDX_W'(i), rand_register_value());
      end
      phase_rows = 0;
      paused = 1'b0;
      while (phase_rows < RANDOM_ROWS / NUM_PHASES) begin
        batch_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 120)) :
                    int'($urandom_range(1, 10));
        for (int k = 0; k < batch_len; k++) begin
          send_row(rand_signal(), rand_signal(), rand_signal(), rand_signal(),
                   1'($urandom_range(0, 1)), k == batch_len - 1);
          pace();
        end
        phase_rows += batch_len;
        // hold off until the result side has caught up
        if (phase == NUM_PHASES / 2 && !paused &&
            phase_rows >= RANDOM_ROWS / NUM_PHASES / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_steady) begin
      out_ready <= 1'b1;
    end else if (rx_left <= 0) begin
      rx_open = !rx_open;
      rx_left = rx_open ? int'($urandom_range(1, 24)) : int'($urandom_range(1, 40));
      out_ready <= rx_open;
    end else begin
      rx_left = rx_left - 1;
    end
  end

  always @(posedge clk) begin : check_results
    batch_score_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("result with no batch pending");
      end else begin
        want = pending_scores.pop_front();
        check_field("brier", 64'(want.brier), 64'(brier));
        check_field("coverage", 64'(want.coverage), 64'(coverage));
        check_field("accept_accuracy", 64'(want.accuracy), 64'(accept_accuracy));
        check_field("item_total", 64'(want.rows), 64'(item_total));
        check_field("accept_total", 64'(want.accepted), 64'(accept_total));
        check_field("correct_accept_total", 64'(want.correct_accepted),
                    64'(correct_accept_total));
        check_field("squared_error_sum", 64'(want.sse), 64'(squared_error_sum));
      end
      batches_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    sig_logprob     = '0;
    sig_entropy     = '0;
    sig_perplexity  = '0;
    sig_consistency = '0;
    is_correct      = 1'b0;
    last_item       = 1'b0;
    weight_reg[0]   = 64'(bssa_pkg::RST_WEIGHT_LOGPROB);
    weight_reg[1]   = 64'(bssa_pkg::RST_WEIGHT_ENTROPY);
    weight_reg[2]   = 64'(bssa_pkg::RST_WEIGHT_PERPLEXITY);
    weight_reg[3]   = 64'(bssa_pkg::RST_WEIGHT_CONSISTENCY);
    threshold_reg   = 64'(bssa_pkg::RST_ACCEPT_THRESHOLD);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_signal_clamping();
    test_register_extremes();
    test_mid_batch_update();
    test_random_batches();

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d rows and %0d batch results with %0d register writes",
             rows_sent, batches_checked, register_writes);
    $display("directed edges, register extremes, mid-batch change, %0d random phases; %0d mismatches",
             NUM_PHASES, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
